### rtl/core/stds_pkg.sv
// ----------------------------------------------------------------------------
// stds_pkg
// Shared types and constants for the slice template dot-product scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package stds_pkg;

    // Fixed field widths
    localparam int ACC_W   = 48;
    localparam int NORM_W  = 16;
    localparam int OUT_W   = 40;
    localparam int IDX_W   = 16;
    localparam int CFG_W   = 5;
    localparam int SPLIT_W = 24;            // low part of the accumulator split
    localparam int SUM_W   = ACC_W + NORM_W;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CFG_W-1:0] SIDE_RESET  = 5'd16;
    localparam logic [CFG_W-1:0] SHIFT_RESET = 5'd15;

    // Saturation limits of the result
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Item opcodes
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_ELEM = 1'b1
    } t_opcode;

    // Register select, taken from paddr[2]
    typedef enum logic {
        REG_SIDE  = 1'b0,
        REG_SHIFT = 1'b1
    } t_reg_sel;

    // Finished slice handed to the scaling pipeline
    typedef struct packed {
        logic signed [ACC_W-1:0]  acc;
        logic signed [NORM_W-1:0] norm;
        logic [IDX_W-1:0]         index;
    } t_slice_res;

endpackage

`default_nettype wire

### rtl/core/stds_ifs.sv
// ----------------------------------------------------------------------------
// stds_ifs
// Valid/ready channels: input items and slice results.
// ----------------------------------------------------------------------------
`default_nettype none

interface stds_item_if
    import stds_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) ();
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [NORM_W-1:0] norm;

    modport source (output valid, output opcode, output sample, output norm, input ready);
    modport sink   (input valid, input opcode, input sample, input norm, output ready);
endinterface

interface stds_result_if
    import stds_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] weighted_sum;
    logic                    saturated;
    logic [IDX_W-1:0]        slice_index;

    modport source (output valid, output weighted_sum, output saturated, output slice_index,
                    input ready);
    modport sink   (input valid, input weighted_sum, input saturated, input slice_index,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/slice_template_dot_scale.sv
// ----------------------------------------------------------------------------
// slice_template_dot_scale
// Template-weighted dot product per slice with norm scaling and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries load items (opcode 0: next template entry, row-major) and
//   weight elements (opcode 1). Each element is multiplied by the template
//   entry at its position and accumulated; the last element of a slice
//   (side_length squared elements) produces one item on o_result.
//   APB registers: 0x0 side_length, 0x4 output_shift. pready is always high.
// Throughput: one item per cycle; the template memory is read once per
//   element and written once per load item, one port access each cycle.
// Pipeline: after the slice's last element is accepted, its result passes the
//   memory read, multiply, accumulate, split multiply, combine and
//   shift/saturate registers before it is valid on o_result.
// Reset: side_length 16, output_shift 15, positions, accumulator and slice
//   count cleared. Template contents are undefined until loaded.
// Stall: a stalled o_result holds its item; the result pipeline fills, then
//   i_item.ready drops once an element with a finished slice cannot move on.
// ----------------------------------------------------------------------------
`default_nettype none

module slice_template_dot_scale
    import stds_pkg::*;
#(
    parameter int SIDE_MAX    = 16,
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    stds_item_if.sink               i_item,
    stds_result_if.source           o_result
);

    localparam int STORE_DEPTH = SIDE_MAX * SIDE_MAX;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int SIDE_W      = $clog2(SIDE_MAX + 1);
    localparam int PROD_W      = 2 * SAMPLE_BITS;

    // ------------------------------------------------------------------
    // configuration registers
    logic [CFG_W-1:0] r_side, r_shift;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side  <= SIDE_RESET;
            r_shift <= SHIFT_RESET;
        end else if (w_cfg_wr) begin
            unique case (t_reg_sel'(paddr[2]))
                REG_SIDE:  r_side  <= pwdata[CFG_W-1:0];
                REG_SHIFT: r_shift <= pwdata[CFG_W-1:0];
                default:   r_side  <= r_side;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_sel'(paddr[2]))
            REG_SIDE:  prdata = PDATA_W'(r_side);
            REG_SHIFT: prdata = PDATA_W'(r_shift);
            default:   prdata = '0;
        endcase
    end

    // active entry count: side clamped to 1..SIDE_MAX, squared
    logic [SIDE_W-1:0] w_side_eff;
    logic [CNT_W-1:0]  w_count;

    always_comb begin
        if (r_side == '0) begin
            w_side_eff = SIDE_W'(1);
        end else if (int'(r_side) > SIDE_MAX) begin
            w_side_eff = SIDE_W'(SIDE_MAX);
        end else begin
            w_side_eff = SIDE_W'(r_side);
        end
        w_count = CNT_W'(w_side_eff) * CNT_W'(w_side_eff);
    end

    // ------------------------------------------------------------------
    // handshake and pipeline control
    logic w_accept, w_load, w_elem;
    logic r_s1_valid, r_s1_last, r_s2_valid, r_s2_last;
    logic n_s1_valid, n_s2_valid;
    logic w_adv1, w_consume2, w_scl_ready;

    assign w_accept = i_item.valid && i_item.ready;
    assign w_load   = w_accept && (t_opcode'(i_item.opcode) == OP_LOAD);
    assign w_elem   = w_accept && (t_opcode'(i_item.opcode) == OP_ELEM);

    always_comb begin
        w_consume2   = r_s2_valid && (!r_s2_last || w_scl_ready);
        w_adv1       = r_s1_valid && (!r_s2_valid || w_consume2);
        i_item.ready = !r_s1_valid || !r_s2_valid || w_consume2;
        n_s1_valid   = w_elem ? 1'b1 : (w_adv1 ? 1'b0 : r_s1_valid);
        n_s2_valid   = w_adv1 ? 1'b1 : (w_consume2 ? 1'b0 : r_s2_valid);
    end

    // ------------------------------------------------------------------
    // load and element positions
    logic [ADDR_W-1:0] r_load_pos, r_elem_pos, n_load_pos, n_elem_pos;
    logic [ADDR_W-1:0] w_ld_base;
    logic [CNT_W-1:0]  w_ld_inc, w_el_inc;
    logic              w_last;

    always_comb begin
        // a position at or past the end wraps before writing
        w_ld_base  = (CNT_W'(r_load_pos) >= w_count) ? '0 : r_load_pos;
        w_ld_inc   = CNT_W'(w_ld_base) + CNT_W'(1);
        n_load_pos = (w_ld_inc >= w_count) ? '0 : w_ld_inc[ADDR_W-1:0];

        w_el_inc   = CNT_W'(r_elem_pos) + CNT_W'(1);
        w_last     = (w_el_inc >= w_count);
        n_elem_pos = w_last ? '0 : w_el_inc[ADDR_W-1:0];
    end

    // ------------------------------------------------------------------
    // template memory: one write (load) or one read (element) per cycle
    logic signed [SAMPLE_BITS-1:0] r_tmpl_mem [STORE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_s1_tmpl;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tmpl_mem[w_ld_base] <= i_item.sample;
        end
        if (w_elem) begin
            r_s1_tmpl <= r_tmpl_mem[r_elem_pos];
        end
    end

    // ------------------------------------------------------------------
    // multiply-accumulate
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic signed [NORM_W-1:0]      r_s1_norm, r_s2_norm;
    logic signed [PROD_W-1:0]      r_s2_prod;
    logic signed [PROD_W+ACC_W-1:0] w_prod_wide;
    logic signed [ACC_W-1:0]       r_acc, n_acc, w_acc_sum;
    logic [IDX_W-1:0]              r_slice_cnt;
    t_slice_res                    w_res;

    always_comb begin
        w_prod_wide = (PROD_W + ACC_W)'(r_s2_prod);
        w_acc_sum   = r_acc + w_prod_wide[ACC_W-1:0];
        n_acc       = r_acc;
        if (w_consume2) begin
            n_acc = r_s2_last ? '0 : w_acc_sum;
        end
        w_res.acc   = w_acc_sum;
        w_res.norm  = r_s2_norm;
        w_res.index = r_slice_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos  <= '0;
            r_elem_pos  <= '0;
            r_acc       <= '0;
            r_slice_cnt <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
        end else begin
            if (w_load) begin
                r_load_pos <= n_load_pos;
            end
            if (w_elem) begin
                r_elem_pos <= n_elem_pos;
            end
            if (w_consume2 && r_s2_last) begin
                r_slice_cnt <= r_slice_cnt + IDX_W'(1);
            end
            r_acc      <= n_acc;
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_elem) begin
            r_s1_sample <= i_item.sample;
            r_s1_norm   <= i_item.norm;
            r_s1_last   <= w_last;
        end
        if (w_adv1) begin
            r_s2_prod <= r_s1_sample * r_s1_tmpl;
            r_s2_norm <= r_s1_norm;
            r_s2_last <= r_s1_last;
        end
    end

    // ------------------------------------------------------------------
    // norm scaling, shift and saturation
    stds_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_consume2 && r_s2_last),
        .i_res    (w_res),
        .o_ready  (w_scl_ready),
        .i_shift  (r_shift),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

### rtl/core/stds_scale.sv
// ----------------------------------------------------------------------------
// stds_scale
// Scales a finished slice sum by its norm, shifts and saturates to 40 bits.
// Four-stage valid/ready pipeline: capture, split multiply, combine, output.
// ----------------------------------------------------------------------------
`default_nettype none

module stds_scale
    import stds_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire t_slice_res       i_res,
    output logic                  o_ready,
    input  wire logic [CFG_W-1:0] i_shift,
    stds_result_if.source         o_result
);

    localparam int HI_W = ACC_W - SPLIT_W;

    // stage valids
    logic r_v3, r_v4, r_v5, r_vo;
    logic n_v3, n_v4, n_v5, n_vo;
    logic w_take4, w_take5, w_take_o;

    // payload
    t_slice_res                          r_s3;
    logic signed [HI_W+NORM_W-1:0]       r_pp_hi;
    logic signed [SPLIT_W+NORM_W:0]      r_pp_lo;
    logic [IDX_W-1:0]                    r_idx4, r_idx5;
    logic signed [SUM_W-1:0]             r_sum;
    logic signed [OUT_W-1:0]             r_out_sum;
    logic                                r_out_sat;
    logic [IDX_W-1:0]                    r_out_idx;

    logic signed [SUM_W-1:0]             w_shifted;
    logic signed [OUT_W-1:0]             w_clip;
    logic                                w_sat;

    // advance conditions, back to front
    always_comb begin
        w_take_o = r_v5 && (!r_vo || o_result.ready);
        w_take5  = r_v4 && (!r_v5 || w_take_o);
        w_take4  = r_v3 && (!r_v4 || w_take5);
        o_ready  = !r_v3 || w_take4;

        n_v3 = i_valid  ? 1'b1 : (w_take4 ? 1'b0 : r_v3);
        n_v4 = w_take4  ? 1'b1 : (w_take5 ? 1'b0 : r_v4);
        n_v5 = w_take5  ? 1'b1 : (w_take_o ? 1'b0 : r_v5);
        n_vo = w_take_o ? 1'b1 : (o_result.ready ? 1'b0 : r_vo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v3 <= n_v3;
            r_v4 <= n_v4;
            r_v5 <= n_v5;
            r_vo <= n_vo;
        end
    end

    // arithmetic shift floors; saturate when bits above the sign disagree
    always_comb begin
        w_shifted = r_sum >>> i_shift;
        w_sat     = !((&w_shifted[SUM_W-1:OUT_W-1]) || !(|w_shifted[SUM_W-1:OUT_W-1]));
        if (w_sat) begin
            w_clip = w_shifted[SUM_W-1] ? OUT_MIN : OUT_MAX;
        end else begin
            w_clip = w_shifted[OUT_W-1:0];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_s3 <= i_res;
        end
        if (w_take4) begin
            // 48 x 16 as two 24 x 16 partial products; the upper half keeps the sign
            r_pp_hi <= $signed(r_s3.acc[ACC_W-1:SPLIT_W]) * r_s3.norm;
            r_pp_lo <= $signed({1'b0, r_s3.acc[SPLIT_W-1:0]}) * r_s3.norm;
            r_idx4  <= r_s3.index;
        end
        if (w_take5) begin
            r_sum  <= (SUM_W'(r_pp_hi) <<< SPLIT_W) + SUM_W'(r_pp_lo);
            r_idx5 <= r_idx4;
        end
        if (w_take_o) begin
            r_out_sum <= w_clip;
            r_out_sat <= w_sat;
            r_out_idx <= r_idx5;
        end
    end

    assign o_result.valid        = r_vo;
    assign o_result.weighted_sum = r_out_sum;
    assign o_result.saturated    = r_out_sat;
    assign o_result.slice_index  = r_out_idx;

endmodule

`default_nettype wire

### rtl/core/stds_chk.sv
// ----------------------------------------------------------------------------
// stds_chk
// Port-level checks on the result channel of slice_template_dot_scale.
// ----------------------------------------------------------------------------
`default_nettype none

module stds_chk
    import stds_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_res_valid,
    input wire logic                    i_res_ready,
    input wire logic signed [OUT_W-1:0] i_weighted_sum,
    input wire logic                    i_saturated,
    input wire logic [IDX_W-1:0]        i_slice_index
);

    // stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_weighted_sum) && $stable(i_saturated)
            && $stable(i_slice_index))
        else $error("result changed while stalled");

    // a clipped result sits on one of the limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_saturated |->
            (i_weighted_sum == OUT_MAX) || (i_weighted_sum == OUT_MIN))
        else $error("saturated result off the limits");

    // nothing is offered in the cycle after a reset edge
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

endmodule

bind slice_template_dot_scale stds_chk u_stds_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_result.valid),
    .i_res_ready    (o_result.ready),
    .i_weighted_sum (o_result.weighted_sum),
    .i_saturated    (o_result.saturated),
    .i_slice_index  (o_result.slice_index)
);

`default_nettype wire

### tb/sv/stds_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stds_checker
// Watches the register port, item and result channels of the slice template
// dot-product scaler. It keeps its own template, positions, accumulator and
// register copies, predicts each slice result and compares it field by field
// with what the block delivers.
// ----------------------------------------------------------------------------

module stds_checker
    import stds_pkg::*;
#(
    parameter int SIDE_MAX    = 16,
    parameter int SAMPLE_BITS = 16
)
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic                          i_pready,
    input  wire logic [PADDR_W-1:0]            i_paddr,
    input  wire logic [PDATA_W-1:0]            i_pwdata,
    input  wire logic                          i_item_valid,
    input  wire logic                          i_item_ready,
    input  wire logic                          i_item_opcode,
    input  wire logic signed [SAMPLE_BITS-1:0] i_item_sample,
    input  wire logic signed [NORM_W-1:0]      i_item_norm,
    input  wire logic                          i_res_valid,
    input  wire logic                          i_res_ready,
    input  wire logic signed [OUT_W-1:0]       i_res_sum,
    input  wire logic                          i_res_saturated,
    input  wire logic [IDX_W-1:0]              i_res_index,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_results
);

    localparam int PROD_W = 2 * SAMPLE_BITS;

    typedef struct packed {
        logic signed [OUT_W-1:0] sum;
        logic                    saturated;
        logic [IDX_W-1:0]        index;
    } t_slice_sum;

    // Predicted slice sums, oldest first
    t_slice_sum                    expected_sums[$];

    logic signed [SAMPLE_BITS-1:0] template_mem [SIDE_MAX*SIDE_MAX];
    int unsigned                   load_pos;
    int unsigned                   elem_pos;
    logic [ACC_W-1:0]              acc_q;
    logic [IDX_W-1:0]              slice_cnt;
    logic [CFG_W-1:0]              side_cfg;
    logic [CFG_W-1:0]              shift_cfg;
    int                            fail_cnt = 0;
    int                            result_cnt = 0;

    // Number of template entries in use; zero counts as 1, large values clip
    function automatic int unsigned active_entries(input logic [CFG_W-1:0] side);
        int unsigned s;
        s = side;
        if (s == 0) s = 1;
        if (s > SIDE_MAX) s = SIDE_MAX;
        return s * s;
    endfunction

    // Apply one accepted item; a slice's last element queues its scaled sum
    task automatic accumulate_item(input logic op,
                                   input logic signed [SAMPLE_BITS-1:0] smp,
                                   input logic signed [NORM_W-1:0] nrm);
        int unsigned              count;
        logic signed [PROD_W-1:0] product;
        longint                   total;
        longint                   scaled;
        t_slice_sum               res;
        count = active_entries(side_cfg);
        if (t_opcode'(op) == OP_LOAD) begin
            // a position past the new end wraps before the write
            if (load_pos >= count) load_pos = 0;
            template_mem[load_pos] = smp;
            load_pos++;
            if (load_pos >= count) load_pos = 0;
        end else begin
            product = smp * template_mem[elem_pos];
            acc_q   = acc_q + {{(ACC_W-PROD_W){product[PROD_W-1]}}, product};
            if (elem_pos + 1 < count) begin
                elem_pos++;
            end else begin
                total  = $signed(acc_q);
                scaled = total * nrm;
                scaled = scaled >>> shift_cfg;
                res.saturated = 1'b1;
                if (scaled > OUT_MAX) begin
                    res.sum = OUT_MAX;
                end else if (scaled < OUT_MIN) begin
                    res.sum = OUT_MIN;
                end else begin
                    res.sum       = scaled[OUT_W-1:0];
                    res.saturated = 1'b0;
                end
                res.index = slice_cnt;
                expected_sums.push_back(res);
                slice_cnt++;
                acc_q    = '0;
                elem_pos = 0;
            end
        end
    endtask

    // Compare one delivered result with the oldest prediction
    task automatic check_result();
        t_slice_sum exp_res;
        if (expected_sums.size() == 0) begin
            $error("slice result (index %0d) delivered with none expected", i_res_index);
            fail_cnt++;
        end else begin
            exp_res = expected_sums.pop_front();
            result_cnt++;
            if (i_res_sum !== exp_res.sum) begin
                $error("weighted_sum: expected %0d, got %0d", exp_res.sum, i_res_sum);
                fail_cnt++;
            end
            if (i_res_saturated !== exp_res.saturated) begin
                $error("saturated: expected %0b, got %0b", exp_res.saturated,
                       i_res_saturated);
                fail_cnt++;
            end
            if (i_res_index !== exp_res.index) begin
                $error("slice_index: expected %0d, got %0d", exp_res.index, i_res_index);
                fail_cnt++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            load_pos  = 0;
            elem_pos  = 0;
            acc_q     = '0;
            slice_cnt = '0;
            side_cfg  = SIDE_RESET;
            shift_cfg = SHIFT_RESET;
            expected_sums.delete();
        end else begin
            if (i_item_valid && i_item_ready) begin
                accumulate_item(i_item_opcode, i_item_sample, i_item_norm);
            end
            if (i_res_valid && i_res_ready) begin
                check_result();
            end
            // register writes land on the access cycle
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_sel'(i_paddr[2]))
                    REG_SIDE: begin
                        side_cfg = i_pwdata[CFG_W-1:0];
                    end
                    REG_SHIFT: begin
                        shift_cfg = i_pwdata[CFG_W-1:0];
                    end
                endcase
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= expected_sums.size();
        o_results    <= result_cnt;
    end

endmodule

### tb/sv/tb_slice_template_dot_scale.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_slice_template_dot_scale
// Drives template loads and weight elements into the scaler through its item
// channel, sets side length and shift over the register port between phases,
// and varies sender gaps and receiver stalls. Checking is left to the
// checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_slice_template_dot_scale;
    import stds_pkg::*;

    localparam int SIDE_MAX       = 16;
    localparam int SAMPLE_BITS    = 16;
    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLDOFF_CYCLES = 100;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int IDLE_HEAVY     = 57;
    localparam int IDLE_BOTH      = 31;
    localparam int LOAD_PCT       = 15;
    localparam int FULL_ENTRIES   = SIDE_MAX * SIDE_MAX;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    stds_item_if #(.SAMPLE_BITS(SAMPLE_BITS)) item_ch ();
    stds_result_if                            res_ch ();

    int fail_count;
    int pending;
    int results_seen;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holdoff_left   = 0;
    int items_sent     = 0;
    int reg_writes     = 0;

    slice_template_dot_scale #(
        .SIDE_MAX    (SIDE_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_item   (item_ch),
        .o_result (res_ch)
    );

    stds_checker #(
        .SIDE_MAX    (SIDE_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_item_valid    (item_ch.valid),
        .i_item_ready    (item_ch.ready),
        .i_item_opcode   (item_ch.opcode),
        .i_item_sample   (item_ch.sample),
        .i_item_norm     (item_ch.norm),
        .i_res_valid     (res_ch.valid),
        .i_res_ready     (res_ch.ready),
        .i_res_sum       (res_ch.weighted_sum),
        .i_res_saturated (res_ch.saturated),
        .i_res_index     (res_ch.slice_index),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_results       (results_seen)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("[slice_template_dot_scale] ERROR");
        $finish;
    end

    // Result receiver: random stalls, or a counted hold-off when requested
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_left > 0) begin
                res_ch.ready = 1'b0;
                holdoff_left--;
            end else begin
                res_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Extremes and small values turn up often; the rest is uniform
    function automatic logic signed [SAMPLE_BITS-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            2: return SAMPLE_BITS'($urandom_range(0, 8)) - SAMPLE_BITS'(4);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Offer one item, with random gaps, and hold it until it is taken
    task automatic send_item(input t_opcode op,
                             input logic signed [SAMPLE_BITS-1:0] smp,
                             input logic signed [NORM_W-1:0] nrm);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid  = 1'b1;
        item_ch.opcode = op;
        item_ch.sample = smp;
        item_ch.norm   = nrm;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Stop offering and wait for every predicted result, then let it settle
    task automatic wait_idle();
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle
    task automatic write_reg(input t_reg_sel sel, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 2'b00};
        pwdata  = PDATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        reg_writes++;
    endtask

    task automatic set_mode(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;          recv_stall_pct = 0;          end
            1: begin send_idle_pct = IDLE_HEAVY; recv_stall_pct = 0;          end
            2: begin send_idle_pct = 0;          recv_stall_pct = IDLE_HEAVY; end
            default: begin send_idle_pct = IDLE_BOTH; recv_stall_pct = IDLE_BOTH; end
        endcase
    endtask

    // Mostly weight elements with some template reloads mixed in
    task automatic run_phase(input int n_items, input logic [CFG_W-1:0] side,
                             input logic [CFG_W-1:0] shift, input int mode);
        wait_idle();
        write_reg(REG_SIDE, side);
        write_reg(REG_SHIFT, shift);
        set_mode(mode);
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < LOAD_PCT)
                send_item(OP_LOAD, pick_value(), pick_value());
            else
                send_item(OP_ELEM, pick_value(), pick_value());
        end
    endtask

    // Stimulus
    initial begin
        int         directed_items;
        int         guard;
        logic [CFG_W-1:0] side;
        item_ch.valid  = 1'b0;
        item_ch.opcode = OP_LOAD;
        item_ch.sample = '0;
        item_ch.norm   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: 2x2 template of extremes, zero shift to force saturation
        write_reg(REG_SIDE, 5'd2);
        write_reg(REG_SHIFT, 5'd0);
        send_item(OP_LOAD, -16'sd32768, 16'sd0);
        send_item(OP_LOAD, 16'sd32767, 16'sd0);
        send_item(OP_LOAD, -16'sd32768, 16'sd0);
        send_item(OP_LOAD, 16'sd32767, 16'sd0);
        // one load past the end wraps onto the first entry
        send_item(OP_LOAD, -16'sd32768, -16'sd1);
        // large positive sum saturates high
        send_item(OP_ELEM, -16'sd32768, 16'sd0);
        send_item(OP_ELEM, 16'sd32767, 16'sd0);
        send_item(OP_ELEM, -16'sd32768, 16'sd0);
        send_item(OP_ELEM, 16'sd32767, 16'sd32767);
        // large negative sum saturates low
        send_item(OP_ELEM, 16'sd32767, 16'sd0);
        send_item(OP_ELEM, -16'sd32768, 16'sd0);
        send_item(OP_ELEM, 16'sd32767, 16'sd0);
        send_item(OP_ELEM, -16'sd32768, 16'sd32767);
        // widest shift: a small negative value floors to -1
        wait_idle();
        write_reg(REG_SHIFT, 5'd31);
        send_item(OP_ELEM, 16'sd1, 16'sd0);
        send_item(OP_ELEM, 16'sd0, 16'sd0);
        send_item(OP_ELEM, 16'sd0, 16'sd0);
        send_item(OP_ELEM, 16'sd0, 16'sd1);
        // side 1: the stale load position wraps before writing
        wait_idle();
        write_reg(REG_SIDE, 5'd1);
        write_reg(REG_SHIFT, 5'd7);
        send_item(OP_LOAD, 16'sd12345, 16'sd0);
        send_item(OP_ELEM, -16'sd1, -16'sd32768);
        // side 0 behaves as side 1
        wait_idle();
        write_reg(REG_SIDE, 5'd0);
        send_item(OP_ELEM, 16'sd32767, 16'sd32767);
        directed_items = items_sent;

        // Fill the whole template with side above the maximum, then one
        // full slice plus a few elements left open for the next phase
        wait_idle();
        write_reg(REG_SIDE, 5'd31);
        write_reg(REG_SHIFT, 5'd20);
        set_mode(3);
        for (int k = 0; k < FULL_ENTRIES; k++)
            send_item(OP_LOAD, pick_value(), pick_value());
        for (int k = 0; k < FULL_ENTRIES + 4; k++)
            send_item(OP_ELEM, pick_value(), pick_value());

        // Random phases; a smaller side mid-slice ends the open slice early
        for (int p = 0; p < 11; p++) begin
            if (p == 5)
                side = 5'd16;
            else
                side = CFG_W'($urandom_range(0, 5));
            run_phase($urandom_range(60, 95), side, CFG_W'($urandom_range(0, 31)), p);
        end

        // Back-pressure: output held off while elements keep coming
        wait_idle();
        write_reg(REG_SIDE, 5'd1);
        write_reg(REG_SHIFT, 5'd16);
        set_mode(0);
        holdoff_left = HOLDOFF_CYCLES;
        for (int k = 0; k < 40; k++)
            send_item(OP_ELEM, pick_value(), pick_value());
        // sender pauses until every result is out
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        set_mode(2);
        for (int k = 0; k < 20; k++)
            send_item(OP_ELEM, pick_value(), pick_value());

        // Drain
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        guard = 0;
        while (pending != 0 && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (pending != 0)
            $error("%0d slice results still outstanding at end of run", pending);

        $display("Run: %0d items (%0d directed), %0d slice results compared, %0d reg writes",
                 items_sent, directed_items, results_seen, reg_writes);
        $display("Side lengths 0 to 31 with clipping, shifts 0 to 31, saturation both ways,");
        $display("four gap/stall mixes and one long output hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("[slice_template_dot_scale] OK");
        end else begin
            $display("[slice_template_dot_scale] ERROR");
        end
        $finish;
    end

endmodule
